[sv/pfd_pkg.sv]
`default_nettype none
package pfd_pkg;

  // Default storage sizes handed to the top level.
  localparam int MAX_LINE_DEF = 2048;
  localparam int MAX_ROWS_DEF = 2048;
  localparam int MIDQ_DEPTH   = 2;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODE         = 2'd0;
  localparam logic [1:0] REG_LINE_WIDTH   = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  // Mode codes; the unused code behaves as pass-through.
  localparam logic [1:0] MODE_PASS  = 2'd0;
  localparam logic [1:0] MODE_FIELD = 2'd1;
  localparam logic [1:0] MODE_BLEND = 2'd2;

  // Plane codes.
  localparam logic [1:0] PLANE_Y = 2'd0;
  localparam logic [1:0] PLANE_V = 2'd2;
  localparam logic [1:0] PLANE_X = 2'd3;

  // Register reset values.
  localparam logic [1:0]  MODE_RST   = MODE_PASS;
  localparam logic [11:0] WIDTH_RST  = 12'd720;
  localparam logic [11:0] HEIGHT_RST = 12'd480;

  typedef struct packed {
    logic [7:0] pixel;
    logic [1:0] plane;
    logic       first_of_plane;
  } pfd_in_t;

  typedef struct packed {
    logic [7:0]  out_pixel;
    logic [1:0]  out_plane;
    logic [10:0] out_row;
    logic [10:0] out_col;
  } pfd_out_t;

  // A classified item on its way from the front to the back.
  typedef struct packed {
    logic [7:0]  pixel;
    logic [1:0]  plane;
    logic [10:0] blend_row;
    logic [10:0] copy_row;
    logic [10:0] col;
    logic        emit_blend;
    logic        emit_copy;
    logic        luma;
  } pfd_item_t;

endpackage
`default_nettype wire

[sv/pfd_front.sv]
`default_nettype none
module pfd_front #(
  parameter int MAX_LINE = pfd_pkg::MAX_LINE_DEF,
  parameter int MAX_ROWS = pfd_pkg::MAX_ROWS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [11:0]                 cfg_wdata,
  input  wire logic                        accept,
  input  wire pfd_pkg::pfd_in_t            in_data,
  output pfd_pkg::pfd_item_t               item,
  output logic [$clog2(MAX_LINE)-1:0]      item_addr
);

  localparam int CW  = $clog2(MAX_LINE);
  localparam int CCW = $clog2(MAX_LINE + 1);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int DWW = (CCW > 12) ? CCW : 12;
  localparam int DHW = (RCW > 12) ? RCW : 12;

  logic [1:0]     mode_r;
  logic [11:0]    line_width_r;
  logic [11:0]    frame_height_r;
  logic [CCW-1:0] col_cnt_r, col_cnt_nxt;
  logic [RCW-1:0] row_cnt_r, row_cnt_nxt;
  logic [1:0]     plane_r, plane_nxt;

  logic [DWW-1:0] w_ext;
  logic [DHW-1:0] h_ext;
  logic [CCW-1:0] w, pw, col_base, col;
  logic [RCW-1:0] h, ph, row_base, row_inc, row, kept, row_m1;
  logic [1:0]     pl_in;
  logic           luma;
  logic [CW+10:0]  col_ext;
  logic [RCW+10:0] row_ext, row_m1_ext, half_ext;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= pfd_pkg::MODE_RST;
      line_width_r   <= pfd_pkg::WIDTH_RST;
      frame_height_r <= pfd_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pfd_pkg::REG_MODE:         mode_r         <= cfg_wdata[1:0];
        pfd_pkg::REG_LINE_WIDTH:   line_width_r   <= cfg_wdata;
        pfd_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Saturate the geometry to the supported range.
  always_comb begin
    w_ext = DWW'(line_width_r);
    h_ext = DHW'(frame_height_r);
    if (w_ext < DWW'(2)) begin
      w = CCW'(2);
    end else if (w_ext > DWW'(MAX_LINE)) begin
      w = CCW'(MAX_LINE);
    end else begin
      w = w_ext[CCW-1:0];
    end
    if (h_ext < DHW'(2)) begin
      h = RCW'(2);
    end else if (h_ext > DHW'(MAX_ROWS)) begin
      h = RCW'(MAX_ROWS);
    end else begin
      h = h_ext[RCW-1:0];
    end
  end

  // Position of the incoming byte: plane latch, then column and row wrap.
  always_comb begin
    pl_in = (in_data.plane == pfd_pkg::PLANE_X) ? pfd_pkg::PLANE_V : in_data.plane;
    if (in_data.first_of_plane) begin
      plane_nxt = pl_in;
      col_base  = '0;
      row_base  = '0;
    end else begin
      plane_nxt = plane_r;
      col_base  = col_cnt_r;
      row_base  = row_cnt_r;
    end
    luma = (plane_nxt == pfd_pkg::PLANE_Y);
    pw   = luma ? w : (w >> 1);
    ph   = luma ? h : (h >> 1);
    if (col_base >= pw) begin
      col     = '0;
      row_inc = row_base + RCW'(1);
    end else begin
      col     = col_base;
      row_inc = row_base;
    end
    row         = (row_inc >= ph) ? '0 : row_inc;
    col_cnt_nxt = col + CCW'(1);
    row_cnt_nxt = row;
  end

  // Classify the byte into the results it causes.
  always_comb begin
    kept       = luma ? (h >> 1) : (h >> 2);
    row_m1     = row - RCW'(1);
    col_ext    = (CW + 11)'(col[CW-1:0]);
    row_ext    = (RCW + 11)'(row);
    row_m1_ext = (RCW + 11)'(row_m1);
    half_ext   = (RCW + 11)'(row >> 1);
    item.pixel      = in_data.pixel;
    item.plane      = plane_nxt;
    item.col        = col_ext[10:0];
    item.blend_row  = row_m1_ext[10:0];
    item.luma       = luma;
    item.emit_blend = 1'b0;
    item.emit_copy  = 1'b1;
    item.copy_row   = row_ext[10:0];
    if (mode_r == pfd_pkg::MODE_FIELD) begin
      item.emit_copy = !row[0] && ((row >> 1) < kept);
      item.copy_row  = half_ext[10:0];
    end else if (mode_r == pfd_pkg::MODE_BLEND && luma) begin
      item.emit_blend = (row >= RCW'(2));
      item.emit_copy  = (row == '0) || (row == ph - RCW'(1));
    end
    item_addr = col[CW-1:0];
  end

  // Position counters advance on every accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      plane_r   <= pfd_pkg::PLANE_Y;
    end else if (accept) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      plane_r   <= plane_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/pfd_queue.sv]
`default_nettype none
module pfd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pfd_pkg::MIDQ_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [NW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == NW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rp_r];

  // Storage slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      cnt_r <= cnt_r + NW'(do_push) - NW'(do_pop);
    end
  end

endmodule
`default_nettype wire

[sv/pfd_back.sv]
`default_nettype none
module pfd_back #(
  parameter int MAX_LINE = pfd_pkg::MAX_LINE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_empty,
  input  wire pfd_pkg::pfd_item_t            q_item,
  input  wire logic [$clog2(MAX_LINE)-1:0]   q_addr,
  output logic                               q_pop,
  output logic                               empty,
  input  wire logic                          pop,
  output pfd_pkg::pfd_out_t                  out_data
);

  localparam int CW = $clog2(MAX_LINE);

  // Line buffer: above row in the upper byte, centre row in the lower byte.
  logic [15:0]        lbuf [MAX_LINE];
  logic [15:0]        rdata_r;
  logic [15:0]        byp_r;
  logic               byp_sel_r;
  logic               b_valid_r, b_valid_nxt;
  pfd_pkg::pfd_item_t b_item_r;
  logic [CW-1:0]      b_addr_r;

  logic [15:0]        rd, wdata;
  logic [9:0]         sum;
  logic               b_adv, b_wr, space;
  logic [1:0]         n_res;
  pfd_pkg::pfd_out_t  res0, res1;

  pfd_pkg::pfd_out_t  oq_r [4];
  logic [1:0]         wp_r, rp_r;
  logic [2:0]         cnt_r;
  logic               oq_pop;

  // Stage handshake: the working stage moves on when two output slots are free.
  assign space       = (cnt_r <= 3'd2);
  assign b_adv       = b_valid_r && space;
  assign q_pop       = !q_empty && (!b_valid_r || b_adv);
  assign b_wr        = b_adv && b_item_r.luma;
  assign b_valid_nxt = q_pop ? 1'b1 : (b_adv ? 1'b0 : b_valid_r);

  // Vertical filter and line buffer update data.
  always_comb begin
    rd    = byp_sel_r ? byp_r : rdata_r;
    sum   = {2'b00, rd[15:8]} + {1'b0, rd[7:0], 1'b0} + {2'b00, b_item_r.pixel};
    wdata = {rd[7:0], b_item_r.pixel};
    res1.out_pixel = b_item_r.pixel;
    res1.out_plane = b_item_r.plane;
    res1.out_row   = b_item_r.copy_row;
    res1.out_col   = b_item_r.col;
    if (b_item_r.emit_blend) begin
      res0.out_pixel = sum[9:2];
      res0.out_plane = b_item_r.plane;
      res0.out_row   = b_item_r.blend_row;
      res0.out_col   = b_item_r.col;
    end else begin
      res0 = res1;
    end
    n_res = b_adv ? (2'(b_item_r.emit_blend) + 2'(b_item_r.emit_copy)) : 2'd0;
  end

  // Line buffer memory: read on entry to the stage, write when a luma item leaves.
  always_ff @(posedge clk) begin
    if (b_wr) begin
      lbuf[b_addr_r] <= wdata;
    end
    if (q_pop) begin
      rdata_r <= lbuf[q_addr];
    end
  end

  // Working stage; a write to the address being read is forwarded.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_item_r  <= q_item;
      b_addr_r  <= q_addr;
      byp_r     <= wdata;
      byp_sel_r <= b_wr && (b_addr_r == q_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
    end
  end

  // Result queue: up to two writes and one read per cycle.
  assign oq_pop   = pop && !empty;
  assign empty    = (cnt_r == 3'd0);
  assign out_data = oq_r[rp_r];

  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      oq_r[wp_r] <= res0;
    end
    if (n_res == 2'd2) begin
      oq_r[wp_r + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + n_res;
      rp_r  <= rp_r + 2'(oq_pop);
      cnt_r <= cnt_r + 3'(n_res) - 3'(oq_pop);
    end
  end

endmodule
`default_nettype wire

[sv/planar_frame_deinterlacer_core.sv]
// Path: a result reaches the ports via the middle queue, the working stage and the result
// queue, all of them registered.
// Throughput: one byte per cycle unless a queue backs up; a blend-mode byte of the last luma
// row yields two results at heights above two; they leave one per cycle, slowing input.
// Reset (rst_n low, synchronous): registers take their reset values, position counters
// clear and both queues empty; the line buffer memory keeps its contents.
`default_nettype none
module planar_frame_deinterlacer_core #(
  parameter int MAX_LINE = pfd_pkg::MAX_LINE_DEF,
  parameter int MAX_ROWS = pfd_pkg::MAX_ROWS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [11:0]       cfg_wdata,
  input  wire logic              push,
  output logic                   full,
  input  wire pfd_pkg::pfd_in_t  in_data,
  output logic                   empty,
  input  wire logic              pop,
  output pfd_pkg::pfd_out_t      out_data
);

  localparam int CW = $clog2(MAX_LINE);
  localparam int QW = $bits(pfd_pkg::pfd_item_t) + CW;

  pfd_pkg::pfd_item_t f_item, q_item;
  logic [CW-1:0]      f_addr, q_addr;
  logic               accept, q_empty, q_pop;

  assign accept = push && !full;

  // Front: registers, position tracking and classification.
  pfd_front #(
    .MAX_LINE(MAX_LINE),
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_data   (in_data),
    .item      (f_item),
    .item_addr (f_addr)
  );

  // Short queue between the two halves.
  pfd_queue #(
    .WIDTH(QW),
    .DEPTH(pfd_pkg::MIDQ_DEPTH)
  ) u_midq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata ({f_item, f_addr}),
    .full  (full),
    .pop   (q_pop),
    .rdata ({q_item, q_addr}),
    .empty (q_empty)
  );

  // Back: line buffer, vertical filter and result queue.
  pfd_back #(
    .MAX_LINE(MAX_LINE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_item   (q_item),
    .q_addr   (q_addr),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

[sv/pfd_checker.sv]
`default_nettype none
module pfd_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              full,
  input wire logic              empty,
  input wire logic              pop,
  input wire pfd_pkg::pfd_out_t out_data
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("results waiting after reset");

  // Reset leaves the input side open.
  a_reset_open: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input full after reset");

  // A waiting result that is not taken stays on the ports unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed or vanished");

  // A result never carries the unused plane code.
  a_out_plane: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.out_plane != pfd_pkg::PLANE_X))
    else $error("result with unused plane code");

endmodule

bind planar_frame_deinterlacer_core pfd_checker u_pfd_checker (.*);
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
module testbench;

  // Codes the package leaves unnamed.
  localparam logic [1:0] PLANE_U    = 2'd1;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int LINE_DEPTH   = pfd_pkg::MAX_LINE_DEF;
  localparam int SETTLE_TICKS = 8;
  localparam int STALL_LIMIT  = 2000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = pfd_pkg::REG_MODE;
  logic [11:0]       cfg_wdata = '0;
  logic              push = 1'b0;
  logic              full;
  pfd_pkg::pfd_in_t  in_data = '0;
  logic              empty;
  logic              pop = 1'b0;
  pfd_pkg::pfd_out_t out_data;

  // Shadow of the block: registers, raster position and the two stored luma lines.
  logic [1:0]  mode_reg = pfd_pkg::MODE_RST;
  logic [11:0] width_reg = pfd_pkg::WIDTH_RST;
  logic [11:0] height_reg = pfd_pkg::HEIGHT_RST;
  logic [1:0]  cur_plane = pfd_pkg::PLANE_Y;
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;
  logic [7:0]  luma_above [LINE_DEPTH];
  logic [7:0]  luma_centre [LINE_DEPTH];
  bit          above_ok [LINE_DEPTH];
  bit          centre_ok [LINE_DEPTH];

  pfd_pkg::pfd_out_t due_samples [$];
  int          errors = 0;
  int unsigned sent_items = 0;
  int unsigned stall_ticks = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  planar_frame_deinterlacer_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Geometry below 2 counts as 2, above the storage size as the storage size.
  function automatic int unsigned clamp_dim(input logic [11:0] v, input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // Works out the plane, row and column that a byte lands on, without changing state.
  function automatic void place_byte(input pfd_pkg::pfd_in_t it, output logic [1:0] pl,
                                     output int unsigned r, output int unsigned c);
    int unsigned lw;
    int unsigned lh;
    lw = clamp_dim(width_reg, pfd_pkg::MAX_LINE_DEF);
    lh = clamp_dim(height_reg, pfd_pkg::MAX_ROWS_DEF);
    if (it.first_of_plane) begin
      pl = (it.plane == pfd_pkg::PLANE_X) ? pfd_pkg::PLANE_V : it.plane;
      r = 0;
      c = 0;
    end else begin
      pl = cur_plane;
      r = row_pos;
      c = col_pos;
    end
    if (c >= ((pl == pfd_pkg::PLANE_Y) ? lw : lw / 2)) begin
      c = 0;
      r++;
    end
    if (r >= ((pl == pfd_pkg::PLANE_Y) ? lh : lh / 2)) r = 0;
  endfunction

  // Predicts the samples one accepted byte produces and advances the shadow state.
  task automatic deinterlace_byte(input pfd_pkg::pfd_in_t it);
    logic [1:0]        pl;
    int unsigned       r;
    int unsigned       c;
    int unsigned       lh;
    int unsigned       ph;
    pfd_pkg::pfd_out_t copy;
    pfd_pkg::pfd_out_t mix;
    place_byte(it, pl, r, c);
    lh = clamp_dim(height_reg, pfd_pkg::MAX_ROWS_DEF);
    ph = (pl == pfd_pkg::PLANE_Y) ? lh : lh / 2;
    cur_plane = pl;
    row_pos = r;
    col_pos = c + 1;
    copy.out_pixel = it.pixel;
    copy.out_plane = pl;
    copy.out_row = 11'(r);
    copy.out_col = 11'(c);
    if (mode_reg == pfd_pkg::MODE_FIELD) begin
      // Only even rows survive, packed into half as many rows.
      if (r % 2 == 0 && r / 2 < ((pl == pfd_pkg::PLANE_Y) ? lh / 2 : lh / 4)) begin
        copy.out_row = 11'(r / 2);
        due_samples.push_back(copy);
      end
    end else if (mode_reg == pfd_pkg::MODE_BLEND && pl == pfd_pkg::PLANE_Y) begin
      // The row above is finished once the row below it arrives.
      if (r >= 2) begin
        mix = copy;
        mix.out_pixel = 8'((int'(luma_above[c]) + 2 * int'(luma_centre[c])
                            + int'(it.pixel)) >> 2);
        mix.out_row = 11'(r - 1);
        due_samples.push_back(mix);
      end
      if (r == 0 || r == ph - 1) due_samples.push_back(copy);
    end else begin
      due_samples.push_back(copy);
    end
    if (pl == pfd_pkg::PLANE_Y) begin
      luma_above[c] = luma_centre[c];
      above_ok[c] = centre_ok[c];
      luma_centre[c] = it.pixel;
      centre_ok[c] = 1'b1;
    end
  endtask

  // Sends one byte; push stays high so that back-to-back transfers need no gap.
  task automatic send_byte(input pfd_pkg::pfd_in_t it);
    logic [1:0]  pl;
    int unsigned r;
    int unsigned c;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    place_byte(it, pl, r, c);
    if (mode_reg == pfd_pkg::MODE_BLEND && pl == pfd_pkg::PLANE_Y && r >= 2
        && !(above_ok[c] && centre_ok[c])) begin
      // A blend here would read line storage never written, so restart the luma plane.
      it.first_of_plane = 1'b1;
      it.plane = pfd_pkg::PLANE_Y;
    end
    in_data <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    deinterlace_byte(it);
    sent_items++;
    @(negedge clk);
  endtask

  // Stops sending and waits until every predicted sample has come out.
  task automatic drain_samples();
    push <= 1'b0;
    while (due_samples.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic set_config(input logic [11:0] mode_word, input logic [11:0] width_word,
                            input logic [11:0] height_word);
    drain_samples();
    cfg_we <= 1'b1;
    cfg_index <= pfd_pkg::REG_MODE;
    cfg_wdata <= mode_word;
    @(negedge clk);
    cfg_index <= pfd_pkg::REG_LINE_WIDTH;
    cfg_wdata <= width_word;
    @(negedge clk);
    cfg_index <= pfd_pkg::REG_FRAME_HEIGHT;
    cfg_wdata <= height_word;
    @(negedge clk);
    cfg_we <= 1'b0;
    mode_reg = mode_word[1:0];
    width_reg = width_word;
    height_reg = height_word;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Favors the two extreme byte values.
  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // A run of bytes; unmarked bytes carry a random plane field that must be ignored.
  task automatic send_plane(input logic [1:0] code, input int unsigned count, input bit mark);
    pfd_pkg::pfd_in_t it;
    for (int unsigned i = 0; i < count; i++) begin
      it.pixel = rand_pixel();
      it.first_of_plane = mark && (i == 0);
      it.plane = it.first_of_plane ? code : 2'($urandom);
      send_byte(it);
    end
  endtask

  task automatic send_frame(input logic [1:0] v_code);
    int unsigned lw;
    int unsigned lh;
    lw = clamp_dim(width_reg, pfd_pkg::MAX_LINE_DEF);
    lh = clamp_dim(height_reg, pfd_pkg::MAX_ROWS_DEF);
    send_plane(pfd_pkg::PLANE_Y, lw * lh, 1'b1);
    send_plane(PLANE_U, (lw / 2) * (lh / 2), 1'b1);
    send_plane(v_code, (lw / 2) * (lh / 2), 1'b1);
  endtask

  // Reset register values: pass-through at 720 x 480, plane latch on unmarked bytes.
  task automatic test_reset_values();
    pfd_pkg::pfd_in_t it;
    it.pixel = 8'h00;
    it.plane = pfd_pkg::PLANE_Y;
    it.first_of_plane = 1'b1;
    send_byte(it);
    it.pixel = 8'hFF;
    it.plane = pfd_pkg::PLANE_V;
    it.first_of_plane = 1'b0;
    send_byte(it);
    send_plane(pfd_pkg::PLANE_Y, 3, 1'b0);
  endtask

  task automatic test_pass_through();
    set_config({10'd0, pfd_pkg::MODE_PASS}, 12'd8, 12'd2);
    send_frame(pfd_pkg::PLANE_V);
  endtask

  // The spare mode copies like pass-through, and the spare plane code means V.
  task automatic test_spare_codes();
    set_config({10'h3FF, MODE_SPARE}, 12'd8, 12'd4);
    send_frame(pfd_pkg::PLANE_X);
  endtask

  task automatic test_one_field();
    set_config({10'd0, pfd_pkg::MODE_FIELD}, 12'd8, 12'd8);
    send_frame(pfd_pkg::PLANE_V);
    // Heights of 2 and 3 keep no chroma rows at all.
    set_config({10'd0, pfd_pkg::MODE_FIELD}, 12'd8, 12'd3);
    send_frame(pfd_pkg::PLANE_V);
    set_config({10'd0, pfd_pkg::MODE_FIELD}, 12'd8, 12'd2);
    send_frame(pfd_pkg::PLANE_X);
  endtask

  task automatic test_linear_blend();
    set_config({10'd0, pfd_pkg::MODE_BLEND}, 12'd8, 12'd5);
    send_frame(pfd_pkg::PLANE_V);
    set_config({10'd0, pfd_pkg::MODE_BLEND}, 12'd8, 12'd3);
    send_frame(pfd_pkg::PLANE_V);
    // With two rows both are copies and nothing is blended.
    set_config({10'd0, pfd_pkg::MODE_BLEND}, 12'd8, 12'd2);
    send_frame(pfd_pkg::PLANE_X);
  endtask

  // Geometry saturation at both ends.
  task automatic test_geometry_limits();
    set_config({10'd0, pfd_pkg::MODE_PASS}, 12'd0, 12'd0);
    send_frame(pfd_pkg::PLANE_V);
    set_config({10'd0, pfd_pkg::MODE_BLEND}, 12'd1, 12'd1);
    send_frame(pfd_pkg::PLANE_V);
    set_config({10'd0, pfd_pkg::MODE_PASS}, 12'hFFF, 12'hFFF);
    send_plane(pfd_pkg::PLANE_Y, 20, 1'b1);
    set_config({10'd0, pfd_pkg::MODE_FIELD}, 12'hFFF, 12'hFFF);
    send_plane(PLANE_U, 20, 1'b1);
  endtask

  // Planes that run on without a mark wrap, also across a pause and a geometry change.
  task automatic test_counter_wrap();
    set_config({10'd0, pfd_pkg::MODE_PASS}, 12'd8, 12'd2);
    send_plane(pfd_pkg::PLANE_Y, 10, 1'b1);
    drain_samples();
    send_plane(pfd_pkg::PLANE_Y, 10, 1'b0);
    set_config({10'd0, pfd_pkg::MODE_PASS}, 12'd12, 12'd4);
    send_plane(pfd_pkg::PLANE_Y, 20, 1'b0);
    set_config({10'd0, pfd_pkg::MODE_BLEND}, 12'd8, 12'd4);
    send_plane(pfd_pkg::PLANE_Y, 20, 1'b0);
    set_config({10'd0, pfd_pkg::MODE_FIELD}, 12'd16, 12'd6);
    send_plane(PLANE_U, 30, 1'b1);
  endtask

  // Mostly whole frames of random geometry and mode, with noise and broken planes.
  task automatic test_random_streams(input int unsigned n_items);
    int unsigned      first_sent;
    logic [11:0]      mode_word;
    logic [11:0]      width_word;
    logic [11:0]      height_word;
    pfd_pkg::pfd_in_t it;
    first_sent = sent_items;
    while (sent_items - first_sent < n_items) begin
      if ($urandom_range(3) != 0) begin
        mode_word = 12'($urandom);
        case ($urandom_range(7))
          0: mode_word[1:0] = MODE_SPARE;
          1, 2: mode_word[1:0] = pfd_pkg::MODE_PASS;
          3, 4: mode_word[1:0] = pfd_pkg::MODE_FIELD;
          default: mode_word[1:0] = pfd_pkg::MODE_BLEND;
        endcase
        width_word = ($urandom_range(9) == 0) ? 12'($urandom_range(7))
                                               : 12'($urandom_range(8, 16));
        height_word = ($urandom_range(9) == 0) ? 12'($urandom_range(1))
                                                : 12'($urandom_range(2, 6));
        set_config(mode_word, width_word, height_word);
      end
      case ($urandom_range(9))
        0: begin
          repeat ($urandom_range(1, 20)) begin
            it.pixel = rand_pixel();
            it.plane = 2'($urandom);
            it.first_of_plane = ($urandom_range(3) == 0);
            send_byte(it);
          end
        end
        1: send_plane(pfd_pkg::PLANE_Y, $urandom_range(1, 40), 1'b1);
        2: send_plane(pfd_pkg::PLANE_Y, $urandom_range(1, 40), 1'b0);
        3: drain_samples();
        default: send_frame(($urandom_range(1) == 0) ? pfd_pkg::PLANE_V : pfd_pkg::PLANE_X);
      endcase
    end
  endtask

  // Result side: random stalls.
  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void check_field(input string name, input logic [10:0] want,
                                      input logic [10:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Each sample transfer is compared with the oldest prediction.
  always @(posedge clk) begin : sample_check
    pfd_pkg::pfd_out_t want;
    if (rst_n && pop && !empty) begin
      if (due_samples.size() == 0) begin
        errors++;
        $display("%0t: unexpected sample, expected none, actual %p", $time, out_data);
      end else begin
        want = due_samples.pop_front();
        check_field("out_pixel", 11'(want.out_pixel), 11'(out_data.out_pixel));
        check_field("out_plane", 11'(want.out_plane), 11'(out_data.out_plane));
        check_field("out_row", want.out_row, out_data.out_row);
        check_field("out_col", want.out_col, out_data.out_col);
      end
    end
  end

  // Ends the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) stall_ticks = 0;
    else stall_ticks++;
    if (stall_ticks >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_idling(15, 71);
    test_reset_values();
    test_pass_through();
    test_spare_codes();
    test_one_field();
    test_linear_blend();
    test_geometry_limits();
    test_counter_wrap();
    test_random_streams(100);
    set_idling(71, 15);
    test_random_streams(100);
    set_idling(0, 0);
    test_random_streams(80);
    drain_samples();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
